/* design/f12ct_pkg.sv */
// ----------------------------------------------------------------------------
// f12ct_pkg
// Shared codes, constants and entry packing helpers for the FAT12 cluster
// table engine.
// ----------------------------------------------------------------------------
package f12ct_pkg;

  localparam logic [2:0] FUNC_READ_ENTRY  = 3'd0;
  localparam logic [2:0] FUNC_WRITE_ENTRY = 3'd1;
  localparam logic [2:0] FUNC_ALLOCATE    = 3'd2;
  localparam logic [2:0] FUNC_FREE_CHAIN  = 3'd3;
  localparam logic [2:0] FUNC_LOAD_BYTE   = 3'd4;
  localparam logic [2:0] FUNC_READ_BYTE   = 3'd5;
  localparam logic [2:0] FUNC_MAP_SECTOR  = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_LOOP   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  localparam logic [1:0] CFG_CLUSTER_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_START_SECTOR    = 2'd1;
  localparam logic [1:0] CFG_CLUSTER_SECTORS = 2'd2;

  localparam logic [11:0] ENTRY_FREE   = 12'h000;
  localparam logic [11:0] ENTRY_EOC    = 12'hFFF;
  localparam logic [11:0] CHAIN_END    = 12'hFF8;
  localparam logic [11:0] FIRST_DATA   = 12'd2;
  localparam logic [12:0] MAX_CLUSTERS = 13'd4096;
  localparam logic [19:0] SECTOR_MAX   = 20'hFFFFF;

  localparam logic [15:0] MASK_LOW12  = 16'h0FFF;
  localparam logic [15:0] MASK_HIGH4  = 16'hF000;
  localparam logic [15:0] MASK_LOW4   = 16'h000F;

  function automatic logic [11:0] entry_get(input logic [15:0] pair, input logic odd);
    logic [15:0] v;
    v = odd ? (pair >> 4) : (pair & MASK_LOW12);
    return v[11:0];
  endfunction

  function automatic logic [15:0] entry_put(input logic [15:0] pair, input logic odd,
                                            input logic [11:0] val);
    logic [15:0] r;
    if (odd) begin
      r = (pair & MASK_LOW4) | ({4'd0, val} << 4);
    end else begin
      r = (pair & MASK_HIGH4) | {4'd0, val};
    end
    return r;
  endfunction

endpackage

/* design/f12ct_ram.sv */
// ----------------------------------------------------------------------------
// f12ct_ram
// Single-port byte bank with registered read data.
// ----------------------------------------------------------------------------
module f12ct_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/fat12_cluster_table_engine_top.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_top
// FAT12 allocation table engine over a flat byte store split into even and
// odd byte banks, so both bytes of an entry pair are read in the same cycle.
// ----------------------------------------------------------------------------
// After reset the block sweeps both banks to zero, one row per cycle, over all
// (TABLE_BYTES+1)/2 rows, and takes no transaction meanwhile; configuration
// writes are taken at any time. One operation is in flight at a time, run by
// a small sequencer around the shared bank port and address adder. Read
// entry, write entry and read byte pass through the read and evaluate
// states, load byte through the read state alone, map sector through one
// registered multiply and then the add and clamp; an out-of-range request or
// the unused selector goes straight to the finish. Allocate reads and compares
// each entry scanned; free chain checks, reads and writes back each link
// freed, and the result waits for a free output register. A finished result
// is held in the output register while the next transaction is accepted.
module fat12_cluster_table_engine_top #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [11:0] cluster,
  input  logic [11:0] entry_in,
  input  logic [12:0] byte_addr,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] entry_out,
  output logic [11:0] found_cluster,
  output logic [19:0] sector_number,
  output logic [7:0]  byte_out,
  output logic [12:0] freed_count,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import f12ct_pkg::*;

  localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int BW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CAP_RAW    = (TABLE_BYTES * 2) / 3;
  localparam int CAP        = (CAP_RAW > 4096) ? 4096 : CAP_RAW;
  localparam logic [12:0] CAP_LIM    = 13'(CAP);
  localparam logic [13:0] STORE_SIZE = 14'(TABLE_BYTES);
  localparam logic [BW-1:0] CLR_LAST = BW'(BANK_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_WALK, S_MUL, S_ADD, S_FIN
  } state_t;

  state_t      state;
  logic [BW-1:0] clr_cnt;

  logic [12:0] cluster_limit;
  logic [15:0] start_sector;
  logic [7:0]  cluster_sectors;

  logic [2:0]  op;
  logic [11:0] cur;
  logic [11:0] ent_val;
  logic [12:0] baddr;
  logic [7:0]  bval;
  logic [19:0] prod;
  logic [12:0] freed;

  logic [11:0] res_entry;
  logic [11:0] res_found;
  logic [19:0] res_sector;
  logic [7:0]  res_byte;
  logic [1:0]  res_status;

  logic [12:0] lim;
  logic [12:0] off;
  logic [11:0] idx_odd;
  logic [11:0] idx_even;
  logic [15:0] old_pair;
  logic [15:0] new_pair;
  logic [11:0] cur_entry;
  logic [11:0] put_val;
  logic [12:0] cur_inc;
  logic [20:0] sector_sum;

  logic          even_we, odd_we;
  logic [BW-1:0] even_addr, odd_addr;
  logic [7:0]    even_wdata, odd_wdata;
  logic [7:0]    even_rdata, odd_rdata;
  logic          pair_we;
  logic          out_free;

  // effective cluster limit
  always_comb begin
    lim = cluster_limit;
    if (lim > MAX_CLUSTERS) lim = MAX_CLUSTERS;
    if (lim > CAP_LIM) lim = CAP_LIM;
  end

  assign off       = {1'b0, cur} + {2'b00, cur[11:1]};
  assign idx_odd   = off[12:1];
  assign idx_even  = off[12:1] + {11'd0, off[0]};
  assign old_pair  = off[0] ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
  assign cur_entry = entry_get(old_pair, cur[0]);
  assign cur_inc   = {1'b0, cur} + 13'd1;
  assign sector_sum = {5'd0, start_sector} + {1'b0, prod};

  always_comb begin
    unique case (op)
      FUNC_WRITE_ENTRY: put_val = ent_val;
      FUNC_ALLOCATE:    put_val = ENTRY_EOC;
      default:          put_val = ENTRY_FREE;
    endcase
  end

  assign new_pair = entry_put(old_pair, cur[0], put_val);

  always_comb begin
    pair_we = 1'b0;
    if (state == S_EVAL) begin
      if (op == FUNC_WRITE_ENTRY || op == FUNC_FREE_CHAIN) pair_we = 1'b1;
      if (op == FUNC_ALLOCATE && cur_entry == ENTRY_FREE) pair_we = 1'b1;
    end
  end

  // bank port selection
  always_comb begin
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_wdata = off[0] ? new_pair[15:8] : new_pair[7:0];
    odd_wdata  = off[0] ? new_pair[7:0] : new_pair[15:8];
    even_addr  = idx_even[BW-1:0];
    odd_addr   = idx_odd[BW-1:0];
    if (state == S_CLEAR) begin
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_wdata = 8'd0;
      odd_wdata  = 8'd0;
      even_addr  = clr_cnt;
      odd_addr   = clr_cnt;
    end else if (op == FUNC_LOAD_BYTE || op == FUNC_READ_BYTE) begin
      even_addr  = baddr[BW:1];
      odd_addr   = baddr[BW:1];
      even_wdata = bval;
      odd_wdata  = bval;
      if (state == S_READ && op == FUNC_LOAD_BYTE) begin
        even_we = !baddr[0];
        odd_we  = baddr[0];
      end
    end else begin
      even_we = pair_we;
      odd_we  = pair_we;
    end
  end

  f12ct_ram #(.DEPTH(BANK_DEPTH), .ADDR_W(BW)) u_even (
    .clk   (clk),
    .we    (even_we),
    .addr  (even_addr),
    .wdata (even_wdata),
    .rdata (even_rdata)
  );

  f12ct_ram #(.DEPTH(BANK_DEPTH), .ADDR_W(BW)) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .addr  (odd_addr),
    .wdata (odd_wdata),
    .rdata (odd_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_limit   <= MAX_CLUSTERS;
      start_sector    <= 16'd0;
      cluster_sectors <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLUSTER_LIMIT:   cluster_limit   <= cfg_data[12:0];
        CFG_START_SECTOR:    start_sector    <= cfg_data;
        CFG_CLUSTER_SECTORS: cluster_sectors <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      op        <= FUNC_READ_ENTRY;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == CLR_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op         <= func;
            ent_val    <= entry_in;
            baddr      <= byte_addr;
            bval       <= byte_in;
            freed      <= 13'd0;
            res_entry  <= 12'd0;
            res_found  <= 12'd0;
            res_sector <= 20'd0;
            res_byte   <= 8'd0;
            cur        <= (func == FUNC_ALLOCATE) ? FIRST_DATA : cluster;
            unique case (func)
              FUNC_READ_ENTRY, FUNC_WRITE_ENTRY: begin
                if ({1'b0, cluster} < lim) begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end
              end
              FUNC_ALLOCATE: begin
                if ({1'b0, FIRST_DATA} < lim) begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_NOFREE;
                  state      <= S_FIN;
                end
              end
              FUNC_FREE_CHAIN: begin
                res_status <= ST_OK;
                state      <= S_WALK;
              end
              FUNC_LOAD_BYTE, FUNC_READ_BYTE: begin
                if ({1'b0, byte_addr} < STORE_SIZE) begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end
              end
              FUNC_MAP_SECTOR: begin
                if (cluster < FIRST_DATA) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_MUL;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          state <= (op == FUNC_LOAD_BYTE) ? S_FIN : S_EVAL;
        end
        S_EVAL: begin
          unique case (op)
            FUNC_READ_ENTRY: begin
              res_entry <= cur_entry;
              state     <= S_FIN;
            end
            FUNC_ALLOCATE: begin
              if (cur_entry == ENTRY_FREE) begin
                res_found <= cur;
                state     <= S_FIN;
              end else if (cur_inc >= lim) begin
                res_status <= ST_NOFREE;
                state      <= S_FIN;
              end else begin
                cur   <= cur_inc[11:0];
                state <= S_READ;
              end
            end
            FUNC_FREE_CHAIN: begin
              freed <= freed + 13'd1;
              cur   <= cur_entry;
              state <= S_WALK;
            end
            FUNC_READ_BYTE: begin
              res_byte <= baddr[0] ? odd_rdata : even_rdata;
              state    <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_WALK: begin
          priority if (cur < FIRST_DATA || cur >= CHAIN_END) begin
            state <= S_FIN;
          end else if (freed >= lim) begin
            res_status <= ST_LOOP;
            state      <= S_FIN;
          end else if ({1'b0, cur} >= lim) begin
            res_status <= ST_RANGE;
            state      <= S_FIN;
          end else begin
            state <= S_READ;
          end
        end
        S_MUL: begin
          prod  <= {8'd0, cur - FIRST_DATA} * {12'd0, cluster_sectors};
          state <= S_ADD;
        end
        S_ADD: begin
          res_sector <= sector_sum[20] ? SECTOR_MAX : sector_sum[19:0];
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            entry_out     <= res_entry;
            found_cluster <= res_found;
            sector_number <= res_sector;
            byte_out      <= res_byte;
            freed_count   <= freed;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
